// File: sv/segx_pkg.sv
// Shared types and constants for the 2D segment intersection block.
`timescale 1ns / 1ps
package segx_pkg;

  localparam int CoordW    = 32;
  localparam int DetMagW   = 63;   // |det| < 2^63
  localparam int NumW      = 66;   // signed numerators
  localparam int NumMagW   = 65;   // |numerator| <= 2^64
  localparam int DividendW = 96;
  localparam int QuoW      = 32;
  localparam int RemW      = 63;
  localparam int DivSteps  = 32;

  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic RegDetThr = 1'b0;  // word index of det_threshold
  localparam logic [DataW-1:0] DetThrReset = 32'd42950;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  localparam int InDataW  = 8 * CoordW;
  localparam int OutDataW = 136;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_INSIDE  = 2'd1,
    OUT_OUTSIDE = 2'd2
  } outcome_e;

  // Classified pair handed from the front to the back.
  typedef struct packed {
    logic                      par;
    logic [CoordW-1:0]         ax;
    logic [CoordW-1:0]         ay;
    logic [CoordW-1:0]         adx_mag;
    logic                      adx_neg;
    logic [CoordW-1:0]         ady_mag;
    logic                      ady_neg;
    logic [NumMagW-1:0]        na_mag;
    logic                      na_neg;
    logic [NumMagW-1:0]        nb_mag;
    logic                      nb_neg;
    logic [DetMagW-1:0]        det_mag;
    logic                      det_neg;
  } job_t;

endpackage

// File: sv/segx_front.sv
// Front: accepts segment pairs, forms the determinant and numerators, classifies.
`timescale 1ns / 1ps
module segx_front import segx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [DataW-1:0]    det_thr_i,
  output logic                push_o,
  output job_t                job_o,
  input  logic                full_i
);

  logic adv;
  logic [3:0] v_q;

  logic signed [CoordW-1:0] s1_ax_q, s1_ay_q, s1_adx_q, s1_ady_q, s1_bdx_q, s1_bdy_q;
  logic signed [CoordW:0]   s1_dx_q, s1_dy_q;

  logic signed [CoordW-1:0] s2_ax_q, s2_ay_q, s2_adx_q, s2_ady_q;
  logic signed [63:0]       s2_pd1_q, s2_pd2_q;
  logic signed [64:0]       s2_pa1_q, s2_pa2_q, s2_pb1_q, s2_pb2_q;

  logic signed [CoordW-1:0] s3_ax_q, s3_ay_q, s3_adx_q, s3_ady_q;
  logic signed [63:0]       s3_det_q;
  logic signed [NumW-1:0]   s3_na_q, s3_nb_q;

  job_t s4_q;
  logic [DetMagW-1:0] det_mag;

  assign adv        = !v_q[3] || !full_i;
  assign in_ready_o = adv;
  assign push_o     = v_q[3] && !full_i;
  assign job_o      = s4_q;

  assign det_mag = s3_det_q[63] ? DetMagW'(-s3_det_q) : s3_det_q[DetMagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ax_q  <= in_data_i[31:0];
      s1_ay_q  <= in_data_i[63:32];
      s1_adx_q <= in_data_i[95:64];
      s1_ady_q <= in_data_i[127:96];
      s1_bdx_q <= in_data_i[223:192];
      s1_bdy_q <= in_data_i[255:224];
      s1_dx_q  <= {in_data_i[31], in_data_i[31:0]} - {in_data_i[159], in_data_i[159:128]};
      s1_dy_q  <= {in_data_i[63], in_data_i[63:32]} - {in_data_i[191], in_data_i[191:160]};

      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_adx_q <= s1_adx_q;
      s2_ady_q <= s1_ady_q;
      s2_pd1_q <= 64'(s1_bdx_q) * 64'(s1_ady_q);
      s2_pd2_q <= 64'(s1_adx_q) * 64'(s1_bdy_q);
      s2_pa1_q <= 65'(s1_dx_q) * 65'(s1_bdy_q);
      s2_pa2_q <= 65'(s1_dy_q) * 65'(s1_bdx_q);
      s2_pb1_q <= 65'(s1_ady_q) * 65'(s1_dx_q);
      s2_pb2_q <= 65'(s1_adx_q) * 65'(s1_dy_q);

      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_adx_q <= s2_adx_q;
      s3_ady_q <= s2_ady_q;
      s3_det_q <= s2_pd1_q - s2_pd2_q;
      s3_na_q  <= NumW'(s2_pa1_q) - NumW'(s2_pa2_q);
      s3_nb_q  <= NumW'(s2_pb1_q) - NumW'(s2_pb2_q);

      // zero determinant is parallel even with a zero threshold
      s4_q.par     <= (det_mag == '0) || (det_mag < DetMagW'(det_thr_i));
      s4_q.ax      <= s3_ax_q;
      s4_q.ay      <= s3_ay_q;
      s4_q.adx_mag <= s3_adx_q[31] ? CoordW'(-s3_adx_q) : s3_adx_q;
      s4_q.adx_neg <= s3_adx_q[31];
      s4_q.ady_mag <= s3_ady_q[31] ? CoordW'(-s3_ady_q) : s3_ady_q;
      s4_q.ady_neg <= s3_ady_q[31];
      s4_q.na_mag  <= s3_na_q[NumW-1] ? NumMagW'(-s3_na_q) : s3_na_q[NumMagW-1:0];
      s4_q.na_neg  <= s3_na_q[NumW-1];
      s4_q.nb_mag  <= s3_nb_q[NumW-1] ? NumMagW'(-s3_nb_q) : s3_nb_q[NumMagW-1:0];
      s4_q.nb_neg  <= s3_nb_q[NumW-1];
      s4_q.det_mag <= det_mag;
      s4_q.det_neg <= s3_det_q[63];
    end
  end

endmodule

// File: sv/segx_fifo.sv
// Short queue between the front and the back.
`timescale 1ns / 1ps
module segx_fifo import segx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: sv/segx_back.sv
// Back: crossing products, four pipelined dividers, sign and saturation.
`timescale 1ns / 1ps
module segx_back import segx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           outcome_o,
  output logic [CoordW-1:0]    fraction_a_o,
  output logic [CoordW-1:0]    fraction_b_o,
  output logic [CoordW-1:0]    cross_x_o,
  output logic [CoordW-1:0]    cross_y_o
);

  // lanes: fraction_a, fraction_b, cross_x, cross_y
  localparam int Lanes = 4;
  localparam logic [CoordW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] SatMin = 32'h8000_0000;
  localparam logic [QuoW-1:0]   OneQ16 = 32'h0001_0000;

  typedef struct packed {
    logic               par;
    logic [CoordW-1:0]  ax;
    logic [CoordW-1:0]  ay;
    logic [DetMagW-1:0] dmag;
    logic [Lanes-1:0]   neg;
    logic [Lanes-1:0]   ovf;
  } bctl_t;

  logic adv;

  // stage B1
  logic               b1_v_q;
  job_t               b1_q;
  logic [64:0]        b1_pxl_q, b1_pyl_q;
  logic [63:0]        b1_pxh_q, b1_pyh_q;

  // stage B2
  logic               b2_v_q;
  bctl_t              b2_ctl_q;
  logic [DividendW-1:0] b2_num_q [Lanes];

  // divider stages, index 0 holds the initial remainder
  logic [DivSteps:0]  dv_q;
  bctl_t              ctl_q [DivSteps+1];
  logic [RemW-1:0]    rem_q [DivSteps+1][Lanes];
  logic [QuoW-1:0]    low_q [DivSteps+1][Lanes];
  logic [QuoW-1:0]    quo_q [DivSteps+1][Lanes];

  bctl_t              ctl0_d;
  logic [RemW-1:0]    rem_d [DivSteps][Lanes];
  logic               qbit  [DivSteps][Lanes];

  // output register
  logic               out_v_q;
  logic [1:0]         outcome_q;
  logic [CoordW-1:0]  res_q [Lanes];

  logic [CoordW-1:0]  res_d [Lanes];
  logic [Lanes-1:0]   in_unit;
  logic [1:0]         outcome_d;

  function automatic logic [CoordW-1:0] sat32(input logic [34:0] v, input logic ovf,
                                               input logic neg);
    logic [CoordW-1:0] r;
    if (ovf) begin
      r = neg ? SatMin : SatMax;
    end else if (v[34:31] != {4{v[34]}}) begin
      r = v[34] ? SatMin : SatMax;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q  <= !empty_i;
      b2_v_q  <= b1_v_q;
      dv_q    <= {dv_q[DivSteps-1:0], b2_v_q};
      out_v_q <= dv_q[DivSteps];
    end
  end

  // B1: split products |ad| * |num_a| into a 32x33 and a 32x32 partial
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q     <= job_i;
      b1_pxl_q <= 65'(job_i.adx_mag) * 65'(job_i.na_mag[32:0]);
      b1_pxh_q <= 64'(job_i.adx_mag) * 64'(job_i.na_mag[64:33]);
      b1_pyl_q <= 65'(job_i.ady_mag) * 65'(job_i.na_mag[32:0]);
      b1_pyh_q <= 64'(job_i.ady_mag) * 64'(job_i.na_mag[64:33]);
    end
  end

  // B2: assemble dividends
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b2_ctl_q.par  <= b1_q.par;
      b2_ctl_q.ax   <= b1_q.ax;
      b2_ctl_q.ay   <= b1_q.ay;
      b2_ctl_q.dmag <= b1_q.det_mag;
      b2_ctl_q.neg  <= {b1_q.ady_neg ^ b1_q.na_neg ^ b1_q.det_neg,
                        b1_q.adx_neg ^ b1_q.na_neg ^ b1_q.det_neg,
                        b1_q.nb_neg ^ b1_q.det_neg,
                        b1_q.na_neg ^ b1_q.det_neg};
      b2_ctl_q.ovf  <= '0;
      b2_num_q[0]   <= {15'd0, b1_q.na_mag, 16'd0};
      b2_num_q[1]   <= {15'd0, b1_q.nb_mag, 16'd0};
      b2_num_q[2]   <= DividendW'(b1_pxl_q) + DividendW'({b1_pxh_q, 33'd0});
      b2_num_q[3]   <= DividendW'(b1_pyl_q) + DividendW'({b1_pyh_q, 33'd0});
    end
  end

  // quotient of 2^32 or more saturates regardless of the low bits
  always_comb begin
    ctl0_d = b2_ctl_q;
    for (int k = 0; k < Lanes; k++) begin
      ctl0_d.ovf[k] = (b2_num_q[k][DividendW-1:QuoW] >= {1'b0, b2_ctl_q.dmag});
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [RemW:0] t;
    for (int s = 0; s < DivSteps; s++) begin
      for (int k = 0; k < Lanes; k++) begin
        t = {rem_q[s][k], low_q[s][k][QuoW-1]};
        qbit[s][k]  = (t >= {1'b0, ctl_q[s].dmag});
        rem_d[s][k] = qbit[s][k] ? RemW'(t - {1'b0, ctl_q[s].dmag}) : t[RemW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl0_d;
      for (int k = 0; k < Lanes; k++) begin
        rem_q[0][k]     <= b2_num_q[k][DividendW-2:QuoW];
        low_q[0][k]     <= b2_num_q[k][QuoW-1:0];
        quo_q[0][k]     <= '0;
      end
      for (int s = 1; s <= DivSteps; s++) begin
        ctl_q[s] <= ctl_q[s-1];
        for (int k = 0; k < Lanes; k++) begin
          rem_q[s][k] <= rem_d[s-1][k];
          low_q[s][k] <= {low_q[s-1][k][QuoW-2:0], 1'b0};
          quo_q[s][k] <= {quo_q[s-1][k][QuoW-2:0], qbit[s-1][k]};
        end
      end
    end
  end

  // sign, offset cross_x and cross_y by the start point, saturate, classify
  always_comb begin
    logic [33:0] sq;
    logic [34:0] v;
    bctl_t       c;
    c = ctl_q[DivSteps];
    for (int k = 0; k < Lanes; k++) begin
      sq = c.neg[k] ? -{2'b00, quo_q[DivSteps][k]} : {2'b00, quo_q[DivSteps][k]};
      case (k)
        2:       v = {{3{c.ax[31]}}, c.ax} + {sq[33], sq};
        3:       v = {{3{c.ay[31]}}, c.ay} + {sq[33], sq};
        default: v = {sq[33], sq};
      endcase
      res_d[k]   = c.par ? '0 : sat32(v, c.ovf[k], c.neg[k]);
      in_unit[k] = !c.ovf[k] && (!c.neg[k] || quo_q[DivSteps][k] == '0)
                   && (quo_q[DivSteps][k] <= OneQ16);
    end
    if (c.par) begin
      outcome_d = OUT_NONE;
    end else if (in_unit[0] && in_unit[1]) begin
      outcome_d = OUT_INSIDE;
    end else begin
      outcome_d = OUT_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      outcome_q <= outcome_d;
      for (int k = 0; k < Lanes; k++) res_q[k] <= res_d[k];
    end
  end

  assign out_valid_o  = out_v_q;
  assign outcome_o    = outcome_q;
  assign fraction_a_o = res_q[0];
  assign fraction_b_o = res_q[1];
  assign cross_x_o    = res_q[2];
  assign cross_y_o    = res_q[3];

endmodule

// File: sv/segment_intersection_2d_top.sv
// Top level of the 2D segment intersection block.
`timescale 1ns / 1ps
// Takes one pair of segments (start point and direction, signed Q16.16) per
// beat and returns one beat per pair: outcome, both segment fractions and the
// crossing point, saturated Q16.16, all zero with outcome 0 when |det| is
// below det_threshold (Q32.32) or det is zero. The block accepts one beat per
// clock unless a full queue holds the front; a result beat passes through four
// front stages, the queue, three stages ahead of the dividers, the 32-stage
// restoring dividers (one quotient bit per stage) and the output register. A
// four-entry queue sits between the determinant front end and the divider back
// end; with no backpressure both run at full rate.
module segment_intersection_2d_top import segx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // low up: seg_a_start_x, seg_a_start_y, seg_a_dir_x, seg_a_dir_y,
  //         seg_b_start_x, seg_b_start_y, seg_b_dir_x, seg_b_dir_y
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // low up: outcome[1:0], fraction_a, fraction_b, cross_x, cross_y, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  logic [DataW-1:0] det_thr_q;
  logic             push, full, pop, empty;
  job_t             fr_job, fifo_job;
  logic [1:0]       outcome;
  logic [CoordW-1:0] frac_a, frac_b, cx, cy;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegDetThr) ? det_thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_thr_q <= DetThrReset;
    end else if (psel && penable && pwrite && pready && paddr[AddrW-1] == RegDetThr) begin
      det_thr_q <= pwdata;
    end
  end

  segx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .det_thr_i  (det_thr_q),
    .push_o     (push),
    .job_o      (fr_job),
    .full_i     (full)
  );

  segx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (fifo_job)
  );

  segx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (fifo_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .outcome_o    (outcome),
    .fraction_a_o (frac_a),
    .fraction_b_o (frac_b),
    .cross_x_o    (cx),
    .cross_y_o    (cy)
  );

  assign m_axis_tdata = {6'd0, cy, cx, frac_b, frac_a, outcome};

endmodule

// File: test/testbench.sv
// Self-checking bench for segment_intersection_2d_top: random and edge pairs vs. a local predictor.
`timescale 1ns / 1ps
module testbench;
  import segx_pkg::*;

  // first member lands in the high bits, so outcome comes last
  typedef struct packed {
    logic [31:0] cy;
    logic [31:0] cx;
    logic [31:0] frac_b;
    logic [31:0] frac_a;
    logic [1:0]  outcome;
  } hit_t;

  localparam logic [AddrW-1:0] AddrDetThr   = {RegDetThr, 2'b00};
  localparam logic [AddrW-1:0] AddrUnmapped = 3'd4;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // low up: a_start_x, a_start_y, a_dir_x, a_dir_y, b_start_x, b_start_y, b_dir_x, b_dir_y
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // low up: outcome, fraction_a, fraction_b, cross_x, cross_y, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  segment_intersection_2d_top u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  logic [31:0] thr_q = DetThrReset;
  hit_t        hits_q[$];
  int          n_err = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cnt = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERR %0t %s got %h exp %h", $time, what, got, exp);
    n_err++;
  endtask

  function automatic logic signed [31:0] sat32(input logic signed [191:0] v);
    if (v > 192'sd2147483647) return 32'h7fffffff;
    if (v < -192'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic hit_t predict_hit(input logic [InDataW-1:0] d);
    logic signed [191:0] ax, ay, adx, ady, bx, by, bdx, bdy, det, na, nb, ta, tb, qx, qy;
    logic [191:0] mag;
    hit_t h;
    ax = $signed(d[31:0]);     ay = $signed(d[63:32]);
    adx = $signed(d[95:64]);   ady = $signed(d[127:96]);
    bx = $signed(d[159:128]);  by = $signed(d[191:160]);
    bdx = $signed(d[223:192]); bdy = $signed(d[255:224]);
    h = '0;
    det = bdx * ady - adx * bdy;
    mag = det < 0 ? -det : det;
    if (det == 0 || mag < {160'd0, thr_q}) return h;
    na = (ax - bx) * bdy - (ay - by) * bdx;
    nb = ady * (ax - bx) - adx * (ay - by);
    // SV signed division truncates toward zero
    ta = (na * 192'sd65536) / det;
    tb = (nb * 192'sd65536) / det;
    qx = ax + (adx * na) / det;
    qy = ay + (ady * na) / det;
    h.outcome = (ta >= 0 && ta <= 65536 && tb >= 0 && tb <= 65536) ? OUT_INSIDE : OUT_OUTSIDE;
    h.frac_a = sat32(ta);
    h.frac_b = sat32(tb);
    h.cx = sat32(qx);
    h.cy = sat32(qy);
    return h;
  endfunction

  task automatic send_pair(input logic [InDataW-1:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hits_q.push_back(predict_hit(d));
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (hits_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_results();
    repeat (60) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] a, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == AddrDetThr) thr_q = v;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [AddrW-1:0] a);
    psel <= 1'b1; pwrite <= 1'b0; paddr <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== thr_q) report("prdata", prdata, thr_q);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h80000000 | $urandom_range(3);
      2: return 32'h7fffffff - $urandom_range(3);
      default: return $signed($urandom_range(20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic logic [InDataW-1:0] rand_pair();
    logic [InDataW-1:0] d;
    for (int i = 0; i < 8; i++) d[i*32 +: 32] = pick_coord();
    case ($urandom_range(9))
      0: d[255:192] = d[127:64];                                 // parallel
      1: d[255:192] = {d[127:96] << 1, (d[95:64] << 1) + 32'd1}; // nearly parallel
      2: d[255:192] = 64'h0;                                     // zero direction
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [InDataW-1:0] make_pair(input int ax, ay, adx, ady, bx, by, bdx, bdy);
    return {bdy, bdx, by, bx, ady, adx, ay, ax};
  endfunction

  task automatic test_directed();
    int one;
    one = 65536;
    send_pair(make_pair(0, 0, one, one, 0, one, one, -one));         // crossing inside
    send_pair(make_pair(0, 0, one, 0, 5 * one, -one, 0, 2 * one));   // outside
    send_pair(make_pair(0, 0, one, 0, one, -one, 0, 2 * one));       // fraction exactly one
    send_pair(make_pair(0, 0, one, 0, 0, -one, 0, 2 * one));         // fraction exactly zero
    send_pair(make_pair(0, 0, one, one, one, 0, 2 * one, 2 * one));  // parallel
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));                     // zero det
    send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));                     // tiny det, under threshold
    send_pair({8{32'h80000000}});
    send_pair({8{32'h7fffffff}});
    send_pair(make_pair(32'h7fffffff, 32'h80000000, 1, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff, 1));
    send_pair(make_pair(32'h80000000, 32'h7fffffff, 32'h80000000, 3,
                        32'h7fffffff, 32'h80000000, 2, 32'h80000000));
    send_pair(make_pair(0, 0, 32'hffffffff, 32'hffffffff, 0, 0, 1, 32'hffffffff));
    for (int i = 0; i < 10; i++) send_pair(rand_pair());
    drain();
  endtask

  task automatic test_threshold();
    logic [31:0] thr_set[4] = '{32'd0, 32'hffffffff, 32'd1, 32'h12345678};
    foreach (thr_set[i]) begin
      apb_write(AddrDetThr, thr_set[i]);
      apb_read_check(AddrDetThr);
      apb_write(AddrUnmapped, $urandom());  // unmapped, ignored
      apb_read_check(AddrDetThr);
      send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
      for (int k = 0; k < 40; k++) send_pair(rand_pair());
      drain();
    end
    apb_write(AddrDetThr, DetThrReset);
  endtask

  task automatic test_random(input int sidle, input int rstall, input int n);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) send_pair(rand_pair());
    drain();
  endtask

  task automatic test_pause();
    for (int i = 0; i < 20; i++) send_pair(rand_pair());
    wait_results();
    for (int i = 0; i < 20; i++) send_pair(rand_pair());
    drain();
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    hit_t got, exp;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[129:0];
        if (hits_q.size() == 0) begin
          report("unexpected beat", got.cx, 32'h0);
        end else begin
          exp = hits_q.pop_front();
          if (got.outcome !== exp.outcome) report("outcome", got.outcome, exp.outcome);
          if (got.frac_a !== exp.frac_a) report("fraction_a", got.frac_a, exp.frac_a);
          if (got.frac_b !== exp.frac_b) report("fraction_b", got.frac_b, exp.frac_b);
          if (got.cx !== exp.cx) report("cross_x", got.cx, exp.cx);
          if (got.cy !== exp.cy) report("cross_y", got.cy, exp.cy);
        end
      end
      m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side and no APB access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold();
    test_random(0, 0, 300);
    test_random(61, 0, 250);
    test_random(0, 61, 250);
    test_random(20, 20, 250);
    test_pause();
    test_random(0, 0, 60);
    if (n_err == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
